FILE: src/rrts_pkg.sv
// rrts_pkg: shared types, codes and sizes for the round robin task switcher
// used by the controller, the datapath, the top level and the checker
// no dependencies
package rrts_pkg;

	localparam int          MAX_TASKS   = 256;
	localparam logic [63:0] STACK_BYTES = 64'd65536;
	localparam int          IDX_W       = 8;
	localparam int          CNT_W       = 9;
	localparam int          PTR_W       = 64;
	localparam int          TS_W        = 2;
	localparam int          STS_W       = 3;

	// stream packing
	localparam int IN_USER_W     = 2;
	localparam int IN_DATA_W     = 3 * PTR_W;
	localparam int OUT_SW_LSB    = STS_W;
	localparam int OUT_RUN_LSB   = OUT_SW_LSB + PTR_W;
	localparam int OUT_REARM_BIT = OUT_RUN_LSB + IDX_W;
	localparam int OUT_LIVE_LSB  = OUT_REARM_BIT + 1;
	localparam int OUT_USED_W    = OUT_LIVE_LSB + CNT_W;
	localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_START  = 2'd1,
		OP_TICK   = 2'd2,
		OP_EXIT   = 2'd3
	} op_t;

	typedef enum logic [TS_W-1:0] {
		TS_IDLE    = 2'd0,
		TS_READY   = 2'd1,
		TS_RUNNING = 2'd2,
		TS_DEAD    = 2'd3
	} task_st_t;

	typedef enum logic [STS_W-1:0] {
		STS_DONE     = 3'd0,
		STS_FULL     = 3'd1,
		STS_BAD_CUR  = 3'd2,
		STS_NO_RUN   = 3'd3,
		STS_BAD_NEXT = 3'd4,
		STS_HALTED   = 3'd5
	} status_t;

	typedef struct packed {
		logic    latch;
		logic    create_wr;
		logic    start_wr;
		logic    exit_wr;
		logic    save_cur;
		logic    srch_run;
		logic    take_next;
		logic    resume_cur;
		logic    load_sp;
		logic    own_run;
		logic    res_set;
		status_t res_status;
		logic    res_rearm;
		logic    res_run_new;
		logic    set_halt;
		logic    out_load;
	} rrts_cmd_t;

	typedef struct packed {
		op_t  op;
		logic halted;
		logic started;
		logic frame_zero;
		logic full;
		logic cur_bad;
		logic srch_found;
		logic srch_none;
		logic cur_dead;
		logic own_hit;
		logic own_none;
		logic own_empty;
	} rrts_stat_t;

endpackage

FILE: src/rrts_ram.sv
// rrts_ram: generic single write port ram with one registered read port
// no dependencies
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/rrts_dp.sv
// rrts_dp: task table memories, scheduler registers, search and ownership walks
// and the result register; depends on rrts_pkg and rrts_ram
module rrts_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrts_pkg::rrts_cmd_t            cmd,
	output rrts_pkg::rrts_stat_t           stat,
	input  logic [rrts_pkg::IN_DATA_W-1:0] in_tdata,
	input  logic [rrts_pkg::IN_USER_W-1:0] in_tuser,
	output logic [rrts_pkg::OUT_DATA_W-1:0] out_tdata
);
	import rrts_pkg::*;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
	                                              input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] nx;
		nx = CNT_W'(idx) + CNT_W'(1);
		return (nx >= cnt) ? '0 : nx[IDX_W-1:0];
	endfunction

	// latched transaction
	op_t              op_q;
	logic [PTR_W-1:0] base_in_q;
	logic [PTR_W-1:0] init_q;
	logic [PTR_W-1:0] frame_q;

	// scheduler state
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cur_q;
	logic             started_q;
	logic             halted_q;
	task_st_t         state0_q;
	task_st_t         cur_st_q;

	// ready search
	logic [IDX_W-1:0] srch_idx_q;
	logic [CNT_W-1:0] srch_left_q;
	logic             chk_v_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             chk_last_s1;

	// owner walk
	logic [IDX_W-1:0] own_idx_q;
	logic [CNT_W-1:0] own_left_q;
	logic             own_v_s1;
	logic             own_last_s1;
	logic [PTR_W-1:0] target_q;

	// result
	logic [PTR_W-1:0] sw_q;
	status_t          res_status_q;
	logic             res_rearm_q;
	logic [IDX_W-1:0] res_run_q;
	status_t          out_status_q;
	logic [PTR_W-1:0] out_sw_q;
	logic [IDX_W-1:0] out_run_q;
	logic             out_rearm_q;
	logic [CNT_W-1:0] out_live_q;

	// memory ports
	logic             st_we;
	logic [IDX_W-1:0] st_waddr;
	task_st_t         st_wdata;
	logic [IDX_W-1:0] st_raddr;
	logic [TS_W-1:0]  st_rd;
	logic             sp_we;
	logic [IDX_W-1:0] sp_waddr;
	logic [PTR_W-1:0] sp_wdata;
	logic [PTR_W-1:0] sp_rd;
	logic [IDX_W-1:0] base_raddr;
	logic [PTR_W-1:0] base_rd;

	task_st_t         st_cur;
	task_st_t         st_new;
	task_st_t         st_chk;
	logic [PTR_W-1:0] base_cur;
	logic             own_match;

	// entry 0 state lives in a register, entry 0 has no stack
	assign st_cur   = (cur_q == '0) ? state0_q : task_st_t'(st_rd);
	assign st_new   = (st_cur == TS_RUNNING) ? TS_READY : st_cur;
	assign st_chk   = (chk_idx_s1 == '0) ? state0_q : task_st_t'(st_rd);
	assign base_cur = (cur_q == '0) ? '0 : base_rd;

	assign own_match = (target_q - base_rd) < STACK_BYTES;

	always_comb begin
		st_we    = 1'b1;
		st_waddr = cur_q;
		st_wdata = TS_RUNNING;
		priority if (cmd.create_wr) begin
			st_waddr = count_q[IDX_W-1:0];
			st_wdata = TS_READY;
		end else if (cmd.exit_wr) begin
			st_wdata = TS_DEAD;
		end else if (cmd.save_cur) begin
			st_wdata = st_new;
		end else if (cmd.take_next) begin
			st_waddr = chk_idx_s1;
		end else if (cmd.resume_cur) begin
			st_wdata = TS_RUNNING;
		end else begin
			st_we = 1'b0;
		end
	end

	assign st_raddr   = cmd.srch_run ? srch_idx_q : cur_q;
	assign sp_we      = cmd.create_wr | cmd.save_cur;
	assign sp_waddr   = cmd.create_wr ? count_q[IDX_W-1:0] : cur_q;
	assign sp_wdata   = cmd.create_wr ? init_q : frame_q;
	assign base_raddr = cmd.own_run ? own_idx_q : cur_q;

	rrts_ram #(.WIDTH(TS_W), .DEPTH(MAX_TASKS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rd)
	);

	rrts_ram #(.WIDTH(PTR_W), .DEPTH(MAX_TASKS)) u_sp_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (chk_idx_s1),
		.rdata (sp_rd)
	);

	rrts_ram #(.WIDTH(PTR_W), .DEPTH(MAX_TASKS)) u_base_ram (
		.clk   (clk),
		.we    (cmd.create_wr),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (base_in_q),
		.raddr (base_raddr),
		.rdata (base_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(1);
			cur_q       <= '0;
			started_q   <= 1'b0;
			halted_q    <= 1'b0;
			state0_q    <= TS_RUNNING;
			chk_v_s1    <= 1'b0;
			own_v_s1    <= 1'b0;
		end else begin
			if (cmd.create_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start_wr) begin
				started_q <= 1'b1;
				state0_q  <= TS_IDLE;
			end
			if (cmd.set_halt) begin
				halted_q <= 1'b1;
			end
			if (cur_q == '0) begin
				if (cmd.exit_wr) begin
					state0_q <= TS_DEAD;
				end
				if (cmd.save_cur) begin
					state0_q <= st_new;
				end
				if (cmd.resume_cur) begin
					state0_q <= TS_RUNNING;
				end
			end
			if (cmd.take_next) begin
				cur_q <= chk_idx_s1;
				if (chk_idx_s1 == '0) begin
					state0_q <= TS_RUNNING;
				end
			end
			chk_v_s1 <= cmd.srch_run && (srch_left_q != '0);
			own_v_s1 <= cmd.own_run && (own_left_q != '0);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= op_t'(in_tuser);
			base_in_q <= in_tdata[PTR_W-1:0];
			init_q    <= in_tdata[2*PTR_W-1:PTR_W];
			frame_q   <= in_tdata[3*PTR_W-1:2*PTR_W];
			sw_q      <= in_tdata[3*PTR_W-1:2*PTR_W];
		end
		if (cmd.save_cur) begin
			cur_st_q    <= st_new;
			srch_idx_q  <= wrap_inc(cur_q, count_q);
			srch_left_q <= count_q;
		end
		if (cmd.srch_run) begin
			if (srch_left_q != '0) begin
				srch_idx_q  <= wrap_inc(srch_idx_q, count_q);
				srch_left_q <= srch_left_q - CNT_W'(1);
			end
			chk_idx_s1  <= srch_idx_q;
			chk_last_s1 <= (srch_left_q == CNT_W'(1));
		end
		if (cmd.load_sp) begin
			target_q   <= sp_rd;
			own_idx_q  <= IDX_W'(1);
			own_left_q <= count_q - CNT_W'(1);
			if (sp_rd != '0) begin
				sw_q <= sp_rd;
			end
		end
		if (cmd.own_run) begin
			if (own_left_q != '0) begin
				own_idx_q  <= own_idx_q + IDX_W'(1);
				own_left_q <= own_left_q - CNT_W'(1);
			end
			own_last_s1 <= (own_left_q == CNT_W'(1));
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_rearm_q  <= cmd.res_rearm;
			res_run_q    <= cmd.res_run_new ? count_q[IDX_W-1:0] : cur_q;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_sw_q     <= sw_q;
			out_run_q    <= res_run_q;
			out_rearm_q  <= res_rearm_q;
			out_live_q   <= count_q;
		end
	end

	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.halted     = halted_q;
		stat.started    = started_q;
		stat.frame_zero = (frame_q == '0);
		stat.full       = (count_q >= CNT_W'(MAX_TASKS));
		stat.cur_bad    = (base_cur != '0) && ((frame_q - base_cur) >= STACK_BYTES);
		stat.srch_found = chk_v_s1 && (st_chk == TS_READY);
		stat.srch_none  = chk_v_s1 && chk_last_s1 && (st_chk != TS_READY);
		stat.cur_dead   = (cur_st_q == TS_DEAD);
		stat.own_hit    = own_v_s1 && own_match;
		stat.own_none   = own_v_s1 && own_last_s1 && !own_match;
		stat.own_empty  = (count_q == CNT_W'(1));
	end

	assign out_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), out_live_q, out_rearm_q,
	                    out_run_q, out_sw_q, out_status_q};

endmodule

FILE: src/rrts_ctrl.sv
// rrts_ctrl: sequencing state machine and stream handshakes
// depends on rrts_pkg
module rrts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  rrts_pkg::rrts_stat_t stat,
	output rrts_pkg::rrts_cmd_t  cmd
);
	import rrts_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_SRCH = 7'b0001000,
		S_LDSP = 7'b0010000,
		S_OWN  = 7'b0100000,
		S_DONE = 7'b1000000
	} ctrl_st_t;

	ctrl_st_t state_q;
	ctrl_st_t state_nx;
	logic     m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_nx  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.res_set = 1'b1;
				state_nx    = S_DONE;
				if (stat.halted) begin
					cmd.res_status = STS_HALTED;
				end else begin
					unique case (stat.op)
						OP_CREATE: begin
							if (stat.full) begin
								cmd.res_status = STS_FULL;
							end else begin
								cmd.create_wr   = 1'b1;
								cmd.res_run_new = 1'b1;
							end
						end
						OP_START: begin
							cmd.start_wr  = 1'b1;
							cmd.res_rearm = 1'b1;
						end
						OP_EXIT: begin
							cmd.exit_wr = 1'b1;
						end
						OP_TICK: begin
							if (stat.frame_zero || !stat.started) begin
								cmd.res_rearm = 1'b1;
							end else begin
								// table reads for the current task issue here
								cmd.res_set = 1'b0;
								state_nx    = S_CHK;
							end
						end
						default: ;
					endcase
				end
			end
			S_CHK: begin
				if (stat.cur_bad) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STS_BAD_CUR;
					cmd.set_halt   = 1'b1;
					state_nx       = S_DONE;
				end else begin
					cmd.save_cur = 1'b1;
					state_nx     = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.srch_run = 1'b1;
				priority if (stat.srch_found) begin
					cmd.take_next = 1'b1;
					state_nx      = S_LDSP;
				end else if (stat.srch_none) begin
					cmd.res_set = 1'b1;
					state_nx    = S_DONE;
					if (stat.cur_dead) begin
						cmd.res_status = STS_NO_RUN;
						cmd.set_halt   = 1'b1;
					end else begin
						cmd.resume_cur = 1'b1;
						cmd.res_rearm  = 1'b1;
					end
				end else begin
				end
			end
			S_LDSP: begin
				cmd.load_sp = 1'b1;
				if (stat.own_empty) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STS_BAD_NEXT;
					cmd.set_halt   = 1'b1;
					state_nx       = S_DONE;
				end else begin
					state_nx = S_OWN;
				end
			end
			S_OWN: begin
				cmd.own_run = 1'b1;
				priority if (stat.own_hit) begin
					cmd.res_set   = 1'b1;
					cmd.res_rearm = 1'b1;
					state_nx      = S_DONE;
				end else if (stat.own_none) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STS_BAD_NEXT;
					cmd.set_halt   = 1'b1;
					state_nx       = S_DONE;
				end else begin
				end
			end
			S_DONE: begin
				// result register frees up in the cycle its transaction completes
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/round_robin_task_switcher.sv
// round_robin_task_switcher: top level, controller plus datapath
// depends on rrts_pkg, rrts_ctrl, rrts_dp (and rrts_ram below it)
//
// channel  | dir | handshake           | content
// ---------+-----+---------------------+------------------------------------------
// s_       | in  | s_tvalid / s_tready | tuser opcode, tdata base, initial sp, frame
// m_       | out | m_tvalid / m_tready | tdata status, switch ptr, index, rearm, live
//
// create, start, exit and any transaction while halted go from accept through the execute and done states
// a tick walks the state ram for the ready search and the stack base ram for the
// owner check, one entry per cycle each
// one transaction in flight; input is taken again once the result sits in the
// output register, which holds until m_tready
// reset clears the scheduler registers; no memory clearing pass is needed
module round_robin_task_switcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: new_stack_base[63:0], new_initial_sp[127:64], frame_pointer[191:128]
	input  logic [rrts_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: opcode[1:0]
	input  logic [rrts_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: status[2:0], switch_pointer[66:3], running_index[74:67],
	// rearm_timer[75], live_count[84:76], zero[87:85]
	output logic [rrts_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rrts_pkg::*;

	rrts_cmd_t  cmd;
	rrts_stat_t stat;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_tdata (m_tdata)
	);

endmodule

FILE: src/rrts_checker.sv
// rrts_checker: port level assertions for the task switcher, bound to the top
// depends on rrts_pkg and round_robin_task_switcher
module rrts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rrts_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rrts_pkg::*;

	logic [STS_W-1:0] sts;
	logic [CNT_W-1:0] live;
	logic             rearm;

	assign sts   = m_tdata[STS_W-1:0];
	assign live  = m_tdata[OUT_LIVE_LSB +: CNT_W];
	assign rearm = m_tdata[OUT_REARM_BIT];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only a clean completion rearms the timer
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (sts != STS_DONE) |-> !rearm)
		else $error("timer rearmed on a refused or faulted transaction");

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (live != '0) && (live <= CNT_W'(MAX_TASKS)))
		else $error("live count out of range");

	// a refused create only happens on a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (sts == STS_FULL) |-> (live == CNT_W'(MAX_TASKS)))
		else $error("table full reported below capacity");

endmodule

bind round_robin_task_switcher rrts_checker u_rrts_checker (.*);
